// ===== hdl/dmf_pkg.sv =====
// ----------------------------------------------------------------------------
// dmf_pkg: shared types and constants of the duplicate message filter
// Holds the parameter defaults, field widths, function codes, the
// sequencer states and the device id trimming function.
// ----------------------------------------------------------------------------
package dmf_pkg;

    localparam int ENTRIES_DEF         = 16;
    localparam int DEVICE_ID_BYTES_DEF = 8;

    localparam int DEVICE_ID_W  = 64;
    localparam int MESSAGE_ID_W = 16;
    localparam int TIME_W       = 32;
    localparam int IN_TDATA_W   = DEVICE_ID_W + MESSAGE_ID_W + TIME_W;
    localparam int OUT_TDATA_W  = 8;

    localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd60000;

    localparam logic FUNC_CHECK  = 1'b0;
    localparam logic FUNC_RECORD = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE,
        ST_FINISH
    } state_t;

    // Keeps the bytes before the first zero byte, at most nbytes of them.
    function automatic logic [DEVICE_ID_W-1:0] canon_id(
        input logic [DEVICE_ID_W-1:0] id,
        input int                     nbytes
    );
        logic [DEVICE_ID_W-1:0] res;
        logic                   stop;
        res  = '0;
        stop = 1'b0;
        for (int k = 0; k < DEVICE_ID_W / 8; k++)
        begin
            if (k >= nbytes || id[8*k +: 8] == 8'h00)
            begin
                stop = 1'b1;
            end
            if (!stop)
            begin
                res[8*k +: 8] = id[8*k +: 8];
            end
        end
        return res;
    endfunction

endpackage

// ===== hdl/dmf_ram.sv =====
// ----------------------------------------------------------------------------
// dmf_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/dmf_cmp.sv =====
// ----------------------------------------------------------------------------
// dmf_cmp: entry compare unit
// Decides whether one stored entry matches the checked key and is still
// younger than the window.
// ----------------------------------------------------------------------------
module dmf_cmp
    import dmf_pkg::*;
#(
    parameter int DEV_W = DEVICE_ID_BYTES_DEF * 8
) (
    input  logic                    entry_valid,
    input  logic [DEV_W-1:0]        entry_device,
    input  logic [MESSAGE_ID_W-1:0] entry_message,
    input  logic [TIME_W-1:0]       entry_time,
    input  logic [DEVICE_ID_W-1:0]  key,
    input  logic [MESSAGE_ID_W-1:0] message_id,
    input  logic [TIME_W-1:0]       now_ms,
    input  logic [TIME_W-1:0]       window_ms,
    output logic                    match
);

    logic [TIME_W-1:0] age;

    // Wrap-around age; the stored id is zero extended so a key with bytes
    // beyond the stored length can never match.
    assign age   = now_ms - entry_time;
    assign match = entry_valid
                && (entry_message == message_id)
                && (DEVICE_ID_W'(entry_device) == key)
                && (age < window_ms);

endmodule

// ===== hdl/duplicate_message_filter_core.sv =====
// ----------------------------------------------------------------------------
// duplicate_message_filter_core: duplicate message filter over a ring
// A check beat (tuser = 0) holds the block from the accepting cycle
// through ST_SCAN, in which the entry RAM delivers one ring entry per
// cycle to the single compare unit, ST_DRAIN, which compares the last
// entry, and ST_FINISH, which loads the result. A record beat (tuser = 1)
// passes through ST_WRITE and loads its result in ST_FINISH. Only one
// item is in flight; the result waits in an output register, and the next
// beat is taken while it waits. A result that is ready while the previous
// one still waits stalls the sequencer, and with it the input.
// ----------------------------------------------------------------------------
module duplicate_message_filter_core
    import dmf_pkg::*;
#(
    parameter int ENTRIES         = ENTRIES_DEF,
    parameter int DEVICE_ID_BYTES = DEVICE_ID_BYTES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [TIME_W-1:0]      cfg_wdata,       // window_ms
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,    // device_id, message_id, now_ms
    input  logic                   s_axis_tuser,    // func
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata     // duplicate, zero padding
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int DEV_W = DEVICE_ID_BYTES * 8;
    localparam int ENT_W = DEV_W + MESSAGE_ID_W + TIME_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    state_t                  state_reg,    state_next;
    logic [TIME_W-1:0]       window_reg;
    logic [ENTRIES-1:0]      valid_reg,    valid_next;
    logic [IDX_W-1:0]        wp_reg,       wp_next;
    logic [IDX_W-1:0]        idx_reg,      idx_next;
    logic [IDX_W-1:0]        cmp_idx_reg,  cmp_idx_next;
    logic                    cmp_pend_reg, cmp_pend_next;
    logic                    hit_reg,      hit_next;
    logic                    func_reg,     func_next;
    logic [DEVICE_ID_W-1:0]  key_reg,      key_next;
    logic [MESSAGE_ID_W-1:0] msg_reg,      msg_next;
    logic [TIME_W-1:0]       now_reg,      now_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_dup_reg,   out_dup_next;

    logic                    in_beat;
    logic                    ram_we;
    logic [ENT_W-1:0]        ram_wdata;
    logic [ENT_W-1:0]        ram_rdata;
    logic                    match;

    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_dup_reg};

    assign ram_we    = (state_reg == ST_WRITE);
    assign ram_wdata = {now_reg, msg_reg, key_reg[DEV_W-1:0]};

    dmf_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    dmf_cmp #(
        .DEV_W (DEV_W)
    ) u_cmp (
        .entry_valid   (valid_reg[cmp_idx_reg]),
        .entry_device  (ram_rdata[DEV_W-1:0]),
        .entry_message (ram_rdata[DEV_W +: MESSAGE_ID_W]),
        .entry_time    (ram_rdata[DEV_W + MESSAGE_ID_W +: TIME_W]),
        .key           (key_reg),
        .message_id    (msg_reg),
        .now_ms        (now_reg),
        .window_ms     (window_reg),
        .match         (match)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            window_reg    <= WINDOW_RESET;
            valid_reg     <= '0;
            wp_reg        <= '0;
            idx_reg       <= '0;
            cmp_idx_reg   <= '0;
            cmp_pend_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            func_reg      <= FUNC_CHECK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
            valid_reg     <= valid_next;
            wp_reg        <= wp_next;
            idx_reg       <= idx_next;
            cmp_idx_reg   <= cmp_idx_next;
            cmp_pend_reg  <= cmp_pend_next;
            hit_reg       <= hit_next;
            func_reg      <= func_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        msg_reg     <= msg_next;
        now_reg     <= now_next;
        out_dup_reg <= out_dup_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        wp_next        = wp_reg;
        idx_next       = idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_pend_next  = cmp_pend_reg;
        hit_next       = hit_reg;
        func_next      = func_reg;
        key_next       = key_reg;
        msg_next       = msg_reg;
        now_next       = now_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_dup_next   = out_dup_reg;

        // A compare issued last cycle sees its RAM data now.
        if (cmp_pend_reg && match)
        begin
            hit_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    func_next = s_axis_tuser;
                    msg_next  = s_axis_tdata[DEVICE_ID_W +: MESSAGE_ID_W];
                    now_next  = s_axis_tdata[DEVICE_ID_W + MESSAGE_ID_W +: TIME_W];
                    hit_next  = 1'b0;
                    idx_next  = '0;
                    if (s_axis_tuser == FUNC_RECORD)
                    begin
                        key_next   = canon_id(s_axis_tdata[DEVICE_ID_W-1:0],
                                              DEVICE_ID_BYTES);
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        key_next   = canon_id(s_axis_tdata[DEVICE_ID_W-1:0],
                                              DEVICE_ID_W / 8);
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmp_pend_next = 1'b1;
                cmp_idx_next  = idx_reg;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                cmp_pend_next = 1'b0;
                state_next    = ST_FINISH;
            end
            ST_WRITE:
            begin
                valid_next[wp_reg] = 1'b1;
                wp_next    = (wp_reg == LAST_IDX) ? '0 : wp_reg + 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_dup_next   = hit_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // The ring pointer moves only when an entry is written.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_WRITE) |=> $stable(wp_reg))
        else $error("write pointer moved outside a record");

    // A record never reports a duplicate.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && func_reg == FUNC_RECORD) |-> !hit_reg)
        else $error("record produced a duplicate flag");

    // A check starts its scan at the first entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && s_axis_tuser == FUNC_CHECK)
            |=> (state_reg == ST_SCAN && idx_reg == '0))
        else $error("scan did not start at entry zero");

    // No compare is left pending once the block is idle again.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !cmp_pend_reg)
        else $error("compare pending while idle");
`endif

endmodule
